FILE: src/aspc_pkg.sv
// Shared types, constants and the sequencer control store for the
// adaptive sample period controller. No dependencies.
`timescale 1ns / 1ps

package aspc_pkg;

	// Field widths
	localparam int TIME_W   = 62;
	localparam int PERIOD_W = 51;
	localparam int TGT_W    = 40;
	localparam int CPU_W    = 11;
	localparam int OFF_W    = 6;
	localparam int AIM_W    = 8;
	localparam int UPPER_W  = 52;
	localparam int PCT_W    = 56;

	// Divider sizing: elapsed*100 is the widest dividend, percent the widest divisor
	localparam int DVD_W = 69;
	localparam int DVS_W = 56;

	// Configuration port
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 40;
	localparam logic [CFG_ADDR_W-1:0] REG_TARGET_DELAY = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CPU_COUNT    = 1'd1;

	// Stream packing
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 56;

	// Algorithm constants
	localparam logic [TGT_W-1:0] MIN_PERIOD_NS = 40'd10000;
	localparam logic [PCT_W-1:0] PCT_LO        = 56'd100;
	localparam logic [PCT_W-1:0] PCT_HI        = 56'd200;
	localparam logic [AIM_W-1:0] AIM_BASE      = 8'd125;
	localparam logic [OFF_W-1:0] OFF_MAX       = 6'd49;
	localparam logic [CPU_W-1:0] CPU_MAX       = 11'd1024;

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,	// ignored, or start
		ST_ON_TGT   = 2'd1,
		ST_ADJUSTED = 2'd2,
		ST_BACKWARD = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ELAPSED,
		OP_DIV_PCT,
		OP_PCT,
		OP_DIV_NEXT,
		OP_ADJUST,
		OP_START,
		OP_IGNORE,
		OP_BACK,
		OP_ONTGT,
		OP_EMIT
	} uop_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_START,
		C_TINY,
		C_NOT_ADV,
		C_DIV_BUSY,
		C_ON_TARGET,
		C_OUT_FULL
	} cond_t;

	localparam int PC_W = 5;

	typedef struct packed {
		uop_t            op;
		cond_t           cond;
		logic [PC_W-1:0] tgt;	// taken when cond holds, else next step
	} ucode_t;

	// Step addresses
	localparam logic [PC_W-1:0] S_WAIT      = 5'd0;
	localparam logic [PC_W-1:0] S_CHK_START = 5'd1;
	localparam logic [PC_W-1:0] S_CHK_TINY  = 5'd2;
	localparam logic [PC_W-1:0] S_CHK_ADV   = 5'd3;
	localparam logic [PC_W-1:0] S_ELAPSED   = 5'd4;
	localparam logic [PC_W-1:0] S_DIV_PCT   = 5'd5;
	localparam logic [PC_W-1:0] S_WAIT_PCT  = 5'd6;
	localparam logic [PC_W-1:0] S_PCT       = 5'd7;
	localparam logic [PC_W-1:0] S_CHK_ONT   = 5'd8;
	localparam logic [PC_W-1:0] S_DIV_NEXT  = 5'd9;
	localparam logic [PC_W-1:0] S_WAIT_NEXT = 5'd10;
	localparam logic [PC_W-1:0] S_ADJUST    = 5'd11;
	localparam logic [PC_W-1:0] S_START     = 5'd12;
	localparam logic [PC_W-1:0] S_IGNORE    = 5'd13;
	localparam logic [PC_W-1:0] S_BACK      = 5'd14;
	localparam logic [PC_W-1:0] S_ONTGT     = 5'd15;
	localparam logic [PC_W-1:0] S_EMIT      = 5'd16;
	localparam logic [PC_W-1:0] S_RETURN    = 5'd17;
	localparam logic [PC_W-1:0] S_LAST      = S_RETURN;

	// Control store
	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			S_WAIT:      w = '{OP_NOP,      C_NO_ITEM,   S_WAIT};
			S_CHK_START: w = '{OP_NOP,      C_START,     S_START};
			S_CHK_TINY:  w = '{OP_NOP,      C_TINY,      S_IGNORE};
			S_CHK_ADV:   w = '{OP_NOP,      C_NOT_ADV,   S_BACK};
			S_ELAPSED:   w = '{OP_ELAPSED,  C_NEVER,     S_WAIT};
			S_DIV_PCT:   w = '{OP_DIV_PCT,  C_NEVER,     S_WAIT};
			S_WAIT_PCT:  w = '{OP_NOP,      C_DIV_BUSY,  S_WAIT_PCT};
			S_PCT:       w = '{OP_PCT,      C_NEVER,     S_WAIT};
			S_CHK_ONT:   w = '{OP_NOP,      C_ON_TARGET, S_ONTGT};
			S_DIV_NEXT:  w = '{OP_DIV_NEXT, C_NEVER,     S_WAIT};
			S_WAIT_NEXT: w = '{OP_NOP,      C_DIV_BUSY,  S_WAIT_NEXT};
			S_ADJUST:    w = '{OP_ADJUST,   C_ALWAYS,    S_EMIT};
			S_START:     w = '{OP_START,    C_ALWAYS,    S_EMIT};
			S_IGNORE:    w = '{OP_IGNORE,   C_ALWAYS,    S_EMIT};
			S_BACK:      w = '{OP_BACK,     C_ALWAYS,    S_EMIT};
			S_ONTGT:     w = '{OP_ONTGT,    C_ALWAYS,    S_EMIT};
			S_EMIT:      w = '{OP_EMIT,     C_OUT_FULL,  S_EMIT};
			S_RETURN:    w = '{OP_NOP,      C_ALWAYS,    S_WAIT};
			default:     w = '{OP_NOP,      C_ALWAYS,    S_WAIT};
		endcase
		return w;
	endfunction

endpackage

FILE: src/aspc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on aspc_pkg for default widths.
`timescale 1ns / 1ps

module aspc_div #(
	parameter int DVD_W = aspc_pkg::DVD_W,
	parameter int DVS_W = aspc_pkg::DVS_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;	// dividend shifts out the top, quotient in the bottom

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = ~diff[DVS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule

FILE: src/adaptive_sample_period_control.sv
// Adaptive sample period controller: microcoded sequencer around a shared divider.
// Depends on aspc_pkg and aspc_div.
`timescale 1ns / 1ps

// Start, ignored fire and backwards clock results skip the divider; an on-target fire
//   takes one 69-step divider pass and an adjusted fire takes two.
// Items are taken one at a time: the next item is accepted in the wait step, reached
//   through the return step after the result is loaded; a stalled output holds it.
// Reset (arst_n low, async): sequencer to its wait step, output empty, timing
//   state and flags zero, target_delay 0, cpu_count 1.
module adaptive_sample_period_control (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [aspc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [aspc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// input items
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [aspc_pkg::S_TDATA_W-1:0]      s_tdata,	// now_ns[61:0], random_offset[67:62]
	input  logic                                s_tuser,	// mode
	// result items
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [aspc_pkg::M_TDATA_W-1:0]      m_tdata,	// new_period[50:0], reprogram[51],
	                                                        // backward_warning[52]
	output logic [1:0]                          m_tuser	// status
);

	localparam int TIME_W   = aspc_pkg::TIME_W;
	localparam int PERIOD_W = aspc_pkg::PERIOD_W;
	localparam int TGT_W    = aspc_pkg::TGT_W;
	localparam int CPU_W    = aspc_pkg::CPU_W;
	localparam int OFF_W    = aspc_pkg::OFF_W;
	localparam int AIM_W    = aspc_pkg::AIM_W;
	localparam int UPPER_W  = aspc_pkg::UPPER_W;
	localparam int PCT_W    = aspc_pkg::PCT_W;
	localparam int DVD_W    = aspc_pkg::DVD_W;
	localparam int DVS_W    = aspc_pkg::DVS_W;
	localparam int PC_W     = aspc_pkg::PC_W;

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	logic [PC_W-1:0]     pc_q;
	logic [TGT_W-1:0]    target_q;
	logic [CPU_W-1:0]    cpu_q;
	logic [TIME_W-1:0]   last_q;	// last sample time
	logic [PERIOD_W-1:0] period_q;	// current programmed period
	logic                wb_q;	// clock went backwards on the last fire
	logic                wg_q;	// one-time warning already raised

	// captured item
	logic                mode_q;
	logic [TIME_W-1:0]   now_q;
	logic [OFF_W-1:0]    off_q;

	// working registers
	logic [TIME_W-1:0]   elapsed_q;
	logic [PCT_W-1:0]    pct_q;
	logic [UPPER_W-1:0]  upper_q;

	// pending result
	aspc_pkg::status_t   res_status_q;
	logic [PERIOD_W-1:0] res_period_q;
	logic                res_reprog_q;
	logic                res_warn_q;

	// output register
	logic                out_valid_q;
	aspc_pkg::status_t   out_status_q;
	logic [PERIOD_W-1:0] out_period_q;
	logic                out_reprog_q;
	logic                out_warn_q;

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	aspc_pkg::ucode_t uc;
	logic             cond_hit;
	logic             out_full;
	logic             in_fire;
	logic             div_busy;
	logic [DVD_W-1:0] div_quot;

	assign uc       = aspc_pkg::ucode(pc_q);
	assign s_tready = (pc_q == aspc_pkg::S_WAIT);
	assign in_fire  = s_tvalid & s_tready;
	assign out_full = out_valid_q & ~m_tready;

	always_comb begin
		unique case (uc.cond)
			aspc_pkg::C_NEVER:     cond_hit = 1'b0;
			aspc_pkg::C_ALWAYS:    cond_hit = 1'b1;
			aspc_pkg::C_NO_ITEM:   cond_hit = ~s_tvalid;
			aspc_pkg::C_START:     cond_hit = ~mode_q;
			aspc_pkg::C_TINY:      cond_hit = (target_q <= aspc_pkg::MIN_PERIOD_NS);
			aspc_pkg::C_NOT_ADV:   cond_hit = (now_q <= last_q);
			aspc_pkg::C_DIV_BUSY:  cond_hit = div_busy;
			aspc_pkg::C_ON_TARGET: cond_hit = (pct_q >= aspc_pkg::PCT_LO) &&
			                                  (pct_q <= aspc_pkg::PCT_HI);
			aspc_pkg::C_OUT_FULL:  cond_hit = out_full;
			default:               cond_hit = 1'b1;
		endcase
	end

	// ---------------------------------------------------------------
	// Datapath arithmetic
	// ---------------------------------------------------------------
	logic [OFF_W-1:0]             off_sat;
	logic [AIM_W-1:0]             aim;
	logic [CPU_W-1:0]             cpus_sat;
	logic [DVD_W-1:0]             dvd_pct;	// elapsed * 100
	logic [DVD_W-TIME_W-1+TIME_W:0] dvd_next_full;
	logic [PERIOD_W+AIM_W-1:0]    next_prod;	// period * aim
	logic [UPPER_W-2:0]           upper_prod;	// cpus * target
	logic [DVD_W-1:0]             div_dvd;
	logic [DVS_W-1:0]             div_dvs;
	logic                         div_start;
	logic [DVD_W-1:0]             clamped;

	assign off_sat  = (off_q > aspc_pkg::OFF_MAX) ? aspc_pkg::OFF_MAX : off_q;
	assign aim      = aspc_pkg::AIM_BASE + {{(AIM_W-OFF_W){1'b0}}, off_sat};
	assign cpus_sat = (cpu_q == '0) ? CPU_W'(1) :
	                  (cpu_q > aspc_pkg::CPU_MAX) ? aspc_pkg::CPU_MAX : cpu_q;

	assign dvd_pct    = {{(DVD_W-TIME_W){1'b0}}, elapsed_q} * DVD_W'(100);
	assign next_prod  = {{AIM_W{1'b0}}, period_q} * {{PERIOD_W{1'b0}}, aim};
	assign upper_prod = {{CPU_W{1'b0}}, target_q} * {{TGT_W{1'b0}}, cpus_sat};
	assign dvd_next_full = {{(DVD_W-PERIOD_W-AIM_W){1'b0}}, next_prod};

	assign div_start = (uc.op == aspc_pkg::OP_DIV_PCT) || (uc.op == aspc_pkg::OP_DIV_NEXT);
	assign div_dvd   = (uc.op == aspc_pkg::OP_DIV_PCT) ? dvd_pct : dvd_next_full;
	assign div_dvs   = (uc.op == aspc_pkg::OP_DIV_PCT) ?
	                   {{(DVS_W-TGT_W){1'b0}}, target_q} : pct_q;

	// new period clamped to [10 us, 2*cpus*target]
	always_comb begin
		if (div_quot < DVD_W'(aspc_pkg::MIN_PERIOD_NS)) begin
			clamped = DVD_W'(aspc_pkg::MIN_PERIOD_NS);
		end else if (div_quot > {{(DVD_W-UPPER_W){1'b0}}, upper_q}) begin
			clamped = {{(DVD_W-UPPER_W){1'b0}}, upper_q};
		end else begin
			clamped = div_quot;
		end
	end

	aspc_div #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	// ---------------------------------------------------------------
	// Control and architectural state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= aspc_pkg::S_WAIT;
			target_q    <= '0;
			cpu_q       <= CPU_W'(1);
			last_q      <= '0;
			period_q    <= '0;
			wb_q        <= 1'b0;
			wg_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= cond_hit ? uc.tgt : pc_q + 1'b1;

			if (cfg_we) begin
				unique case (cfg_addr)
					aspc_pkg::REG_TARGET_DELAY: target_q <= cfg_wdata[TGT_W-1:0];
					aspc_pkg::REG_CPU_COUNT:    cpu_q    <= cfg_wdata[CPU_W-1:0];
					default: ;
				endcase
			end

			if (uc.op == aspc_pkg::OP_EMIT && !out_full) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (uc.op)
				aspc_pkg::OP_START: begin
					last_q   <= now_q;
					period_q <= {{(PERIOD_W-TGT_W){1'b0}}, target_q};
				end
				aspc_pkg::OP_ELAPSED: begin
					last_q <= now_q;
					wb_q   <= 1'b0;
				end
				aspc_pkg::OP_BACK: begin
					last_q <= now_q;
					wb_q   <= 1'b1;
					if (wb_q) begin
						wg_q <= 1'b1;
					end
				end
				aspc_pkg::OP_ADJUST: begin
					period_q <= clamped[PERIOD_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= s_tuser;
			now_q  <= s_tdata[TIME_W-1:0];
			off_q  <= s_tdata[TIME_W+OFF_W-1:TIME_W];
		end

		if (uc.op == aspc_pkg::OP_EMIT && !out_full) begin
			out_status_q <= res_status_q;
			out_period_q <= res_period_q;
			out_reprog_q <= res_reprog_q;
			out_warn_q   <= res_warn_q;
		end

		unique case (uc.op)
			aspc_pkg::OP_ELAPSED: begin
				elapsed_q <= now_q - last_q;
			end
			aspc_pkg::OP_PCT: begin
				// percent never below one
				pct_q <= (div_quot == '0) ? PCT_W'(1) : div_quot[PCT_W-1:0];
			end
			aspc_pkg::OP_DIV_NEXT: begin
				upper_q <= {upper_prod, 1'b0};
			end
			aspc_pkg::OP_START: begin
				res_status_q <= aspc_pkg::ST_IDLE;
				res_period_q <= {{(PERIOD_W-TGT_W){1'b0}}, target_q};
				res_reprog_q <= 1'b1;
				res_warn_q   <= 1'b0;
			end
			aspc_pkg::OP_IGNORE: begin
				res_status_q <= aspc_pkg::ST_IDLE;
				res_period_q <= period_q;
				res_reprog_q <= 1'b0;
				res_warn_q   <= 1'b0;
			end
			aspc_pkg::OP_BACK: begin
				res_status_q <= aspc_pkg::ST_BACKWARD;
				res_period_q <= period_q;
				res_reprog_q <= 1'b0;
				res_warn_q   <= wb_q & ~wg_q;
			end
			aspc_pkg::OP_ONTGT: begin
				res_status_q <= aspc_pkg::ST_ON_TGT;
				res_period_q <= period_q;
				res_reprog_q <= 1'b0;
				res_warn_q   <= 1'b0;
			end
			aspc_pkg::OP_ADJUST: begin
				res_status_q <= aspc_pkg::ST_ADJUSTED;
				res_period_q <= clamped[PERIOD_W-1:0];
				res_reprog_q <= 1'b1;
				res_warn_q   <= 1'b0;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(aspc_pkg::M_TDATA_W-PERIOD_W-2){1'b0}},
	                   out_warn_q, out_reprog_q, out_period_q};

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// sequencer stays inside the program
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= aspc_pkg::S_LAST)
		else $error("sequencer left the program");

	// divider is never restarted mid-run
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// an adjusted period lands inside the clamp window
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(uc.op == aspc_pkg::OP_ADJUST) |=>
		(period_q >= PERIOD_W'(aspc_pkg::MIN_PERIOD_NS)) &&
		({1'b0, period_q} <= upper_q))
		else $error("adjusted period outside clamp");

	// warning flag is sticky
	a_warn_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wg_q |=> wg_q)
		else $error("warning flag cleared");

	// reprogram only goes with a start or an adjustment
	a_reprog: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_reprog_q) |->
		(out_status_q == aspc_pkg::ST_IDLE || out_status_q == aspc_pkg::ST_ADJUSTED))
		else $error("reprogram with wrong status");

endmodule

FILE: tb/adaptive_sample_period_control_tb.sv
// Self-checking bench for adaptive_sample_period_control: queued stimulus, clocked
// stream driver and result monitor, and an in-bench model of the period controller.
// Depends on aspc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module adaptive_sample_period_control_tb;
	import aspc_pkg::*;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_FIRE  = 1'b1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic              mode;
		logic [TIME_W-1:0] now;
		logic [OFF_W-1:0]  offset;
	} sample_item_t;

	typedef struct packed {
		status_t             status;
		logic [PERIOD_W-1:0] new_period;
		logic                reprogram;
		logic                warning;
	} period_result_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	// block ports
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;	// now_ns[61:0], random_offset[67:62], zero pad
	logic                  s_tuser = 1'b0;	// mode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;	// new_period[50:0], reprogram[51], backward_warning[52]
	logic [1:0]            m_tuser;	// status

	adaptive_sample_period_control i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// model state: register copies plus the controller's own timing state
	logic [TGT_W-1:0]    target_cfg = '0;
	logic [CPU_W-1:0]    cpu_cfg = 11'd1;
	logic [TIME_W-1:0]   last_time = '0;
	logic [PERIOD_W-1:0] cur_period = '0;
	logic                back_flag = 1'b0;
	logic                warned = 1'b0;

	sample_item_t   pending_items[$];	// waiting to be offered
	period_result_t awaited_results[$];	// predicted, not yet seen
	sample_item_t   cur_item;
	logic [TIME_W-1:0] gen_t = '0;		// last time stamp queued by the generator
	int n_pushed = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_fail = 0;

	// Advance the controller model by one accepted item and return its result.
	function automatic period_result_t advance_period_ctl(input sample_item_t it);
		logic [127:0] elapsed, pct, nxt, upper, tgt, cpus;
		logic [OFF_W-1:0] off;
		period_result_t res;
		res.status     = ST_IDLE;
		res.new_period = cur_period;
		res.reprogram  = 1'b0;
		res.warning    = 1'b0;
		tgt = 128'(target_cfg);
		if (it.mode == MODE_START) begin
			// start: latch time, reload period (a zero target also reprograms)
			last_time      = it.now;
			cur_period     = PERIOD_W'(target_cfg);
			res.new_period = PERIOD_W'(target_cfg);
			res.reprogram  = 1'b1;
		end else if (target_cfg > MIN_PERIOD_NS) begin
			if (it.now <= last_time) begin
				// clock stood still or went back; warn once on a second one in a row
				res.status = ST_BACKWARD;
				if (back_flag && !warned) begin
					warned      = 1'b1;
					res.warning = 1'b1;
				end
				back_flag = 1'b1;
				last_time = it.now;
			end else begin
				elapsed   = 128'(it.now);
				elapsed   = elapsed - 128'(last_time);
				last_time = it.now;
				back_flag = 1'b0;
				pct = (elapsed * 128'd100) / tgt;
				if (pct == 128'd0)
					pct = 128'd1;
				if (pct >= 128'(PCT_LO) && pct <= 128'(PCT_HI)) begin
					res.status = ST_ON_TGT;
				end else begin
					off = (it.offset > OFF_MAX) ? OFF_MAX : it.offset;
					nxt = 128'(cur_period);
					nxt = (nxt * (128'(AIM_BASE) + 128'(off))) / pct;
					cpus = 128'(cpu_cfg);
					if (cpus == 128'd0)
						cpus = 128'd1;
					else if (cpus > 128'(CPU_MAX))
						cpus = 128'(CPU_MAX);
					upper = 128'd2 * cpus * tgt;
					if (nxt < 128'(MIN_PERIOD_NS))
						nxt = 128'(MIN_PERIOD_NS);
					else if (nxt > upper)
						nxt = upper;
					cur_period     = nxt[PERIOD_W-1:0];
					res.status     = ST_ADJUSTED;
					res.new_period = cur_period;
					res.reprogram  = 1'b1;
				end
			end
		end
		// tiny or zero target: fire ignored, nothing changes
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Driver: offers queued items in bursts with random gaps between them.
	// Prediction happens at acceptance so the model sees items in DUT order.
	// ---------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;
	int gap_kind;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				awaited_results.push_back(advance_period_ctl(cur_item));
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'b0, cur_item.offset, cur_item.now};
					s_tuser  <= cur_item.mode;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// new burst; gap long enough now and then to land anywhere
						// inside the divider passes
						burst_left = $urandom_range(1, 24);
						gap_kind   = $urandom_range(0, 9);
						if (gap_kind < 4)
							gap_left = 0;
						else if (gap_kind < 8)
							gap_left = $urandom_range(1, 8);
						else if (gap_kind == 8)
							gap_left = $urandom_range(9, 60);
						else
							gap_left = $urandom_range(61, 160);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: checks each result item against the oldest prediction and
	// drives tready on a rotating stall pattern, with one long hold-off.
	// ---------------------------------------------------------------------
	period_result_t want;
	logic [11:0] rx_cycle = '0;
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			rx_cycle  <= '0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result item: status %0d new_period %0d",
						m_tuser, m_tdata[PERIOD_W-1:0]);
					n_fail++;
				end else begin
					want = awaited_results.pop_front();
					if (m_tuser != want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_tuser);
						n_fail++;
					end
					if (m_tdata[PERIOD_W-1:0] != want.new_period) begin
						$error("new_period: expected %0d, actual %0d",
							want.new_period, m_tdata[PERIOD_W-1:0]);
						n_fail++;
					end
					if (m_tdata[PERIOD_W] != want.reprogram) begin
						$error("reprogram: expected %0d, actual %0d",
							want.reprogram, m_tdata[PERIOD_W]);
						n_fail++;
					end
					if (m_tdata[PERIOD_W+1] != want.warning) begin
						$error("backward_warning: expected %0d, actual %0d",
							want.warning, m_tdata[PERIOD_W+1]);
						n_fail++;
					end
				end
				n_results++;
				// long hold-off once, mid-run: the sender keeps offering so the
				// block backs up and drops s_tready
				if (n_results == 150)
					hold_left = 400;
			end
			rx_cycle <= rx_cycle + 1'b1;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_cycle[10:9])
					2'd0: m_tready <= 1'b1;
					2'd1: m_tready <= ($urandom_range(0, 3) != 0);
					2'd2: m_tready <= (rx_cycle[2:0] < 3'd3);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	task automatic push(input logic mode, input logic [TIME_W-1:0] now,
			input logic [OFF_W-1:0] off);
		sample_item_t it;
		it.mode   = mode;
		it.now    = now;
		it.offset = off;
		pending_items.push_back(it);
		gen_t = now;
		n_pushed++;
	endtask

	// register writes only while the block is idle
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TARGET_DELAY)
			target_cfg = val;
		else
			cpu_cfg = val[CPU_W-1:0];
	endtask

	task automatic configure(input logic [TGT_W-1:0] tgt, input logic [CPU_W-1:0] cpus);
		write_reg(REG_TARGET_DELAY, tgt);
		write_reg(REG_CPU_COUNT, CFG_DATA_W'(cpus));
	endtask

	// wait until every queued item was taken and every result came back
	task automatic drain();
		while (n_accepted != n_pushed || awaited_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [OFF_W-1:0] pick_offset();
		if ($urandom_range(0, 6) == 0)
			return OFF_W'($urandom_range(50, 63));	// saturates to 49
		return OFF_W'($urandom_range(0, 49));
	endfunction

	// Mostly start-then-fires sequences with elapsed times steered into each
	// percent band; the rest is noise with random mode and full-range times.
	task automatic random_phase(input int n_items);
		int left, k, cls;
		logic [63:0] tgt, step, r64;
		left = n_items;
		tgt = (target_cfg != 0) ? 64'(target_cfg) : 64'd1_000_000;
		while (left > 0) begin
			r64 = {$urandom, $urandom};
			if ($urandom_range(0, 4) == 0) begin
				push(1'($urandom_range(0, 1)), r64[TIME_W-1:0], OFF_W'($urandom_range(0, 63)));
				left--;
			end else begin
				if ($urandom_range(0, 5) != 0) begin
					push(MODE_START, r64[TIME_W-1:0], OFF_W'($urandom_range(0, 63)));
					left--;
				end
				k = $urandom_range(1, 14);
				while (k > 0 && left > 0) begin
					cls = $urandom_range(0, 99);
					if (cls < 30) begin
						step = tgt * $urandom_range(100, 200) / 100;	// on target
						push(MODE_FIRE, gen_t + step[TIME_W-1:0], pick_offset());
					end else if (cls < 55) begin
						step = tgt * $urandom_range(0, 99) / 100 + $urandom_range(1, 50);
						push(MODE_FIRE, gen_t + step[TIME_W-1:0], pick_offset());
					end else if (cls < 78) begin
						step = tgt * $urandom_range(201, 3000) / 100;	// too slow
						push(MODE_FIRE, gen_t + step[TIME_W-1:0], pick_offset());
					end else if (cls < 83) begin
						r64 = {$urandom, $urandom};
						step = r64 >> $urandom_range(2, 40);		// huge gap
						push(MODE_FIRE, gen_t + step[TIME_W-1:0], pick_offset());
					end else if (cls < 93) begin
						// clock stands still or steps back
						push(MODE_FIRE, gen_t - TIME_W'($urandom_range(0, 2000)), pick_offset());
					end else begin
						// band edges: exactly 100 and 200 percent, just outside them
						case ($urandom_range(0, 3))
							0: step = tgt;
							1: step = tgt * 2;
							2: step = tgt * 2 + tgt / 100;
							default: step = tgt - tgt / 100;
						endcase
						push(MODE_FIRE, gen_t + step[TIME_W-1:0], pick_offset());
					end
					k--;
					left--;
				end
			end
		end
	endtask

	task automatic run_phase(input logic [TGT_W-1:0] tgt, input logic [CPU_W-1:0] cpus,
			input int n_items);
		configure(tgt, cpus);
		random_phase(n_items);
		drain();
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: target zero, every fire ignored
		push(MODE_FIRE, '0, 6'd0);
		push(MODE_FIRE, TIME_MAX, 6'd63);
		drain();

		// directed: 1 ms target, 4 cpus
		configure(40'd1_000_000, 11'd4);
		push(MODE_FIRE, 62'd5_000_000, 6'd10);		// fire before any start: 0 -> min clamp
		push(MODE_START, 62'd1000, 6'd0);
		push(MODE_FIRE, gen_t + 62'd1_000_000, 6'd0);	// exactly 100 percent
		push(MODE_FIRE, gen_t + 62'd2_000_000, 6'd0);	// exactly 200 percent
		push(MODE_FIRE, gen_t + 62'd2_010_000, 6'd0);	// 201 percent
		push(MODE_FIRE, gen_t + 62'd990_000, 6'd49);	// 99 percent
		push(MODE_FIRE, gen_t + 62'd5_000, 6'd63);	// percent floors to 1, offset saturates
		push(MODE_FIRE, gen_t, 6'd20);			// clock stands still
		push(MODE_FIRE, gen_t - 62'd1, 6'd20);		// second in a row: warning
		push(MODE_FIRE, gen_t - 62'd1, 6'd20);		// warning only once
		push(MODE_FIRE, gen_t + 62'd1_500_000, 6'd5);	// advances, clears flag
		push(MODE_FIRE, gen_t - 62'd7, 6'd5);
		push(MODE_FIRE, gen_t - 62'd7, 6'd5);
		push(MODE_FIRE, gen_t + 62'd9_999, 6'd50);
		push(MODE_FIRE, TIME_MAX, 6'd30);		// huge elapsed: min clamp
		push(MODE_START, '0, 6'd0);
		push(MODE_FIRE, TIME_MAX, 6'd25);		// largest possible elapsed
		push(MODE_FIRE, '0, 6'd25);
		push(MODE_START, 62'h2AAA_AAAA_AAAA_AAAA, 6'd0);
		drain();

		// target at the ignore threshold, cpu count below range
		configure(40'd10_000, 11'd0);
		push(MODE_START, 62'd100, 6'd0);
		push(MODE_FIRE, gen_t + 62'd5_000_000, 6'd0);
		drain();

		// smallest active target, cpu count above range
		configure(40'd10_001, 11'd2047);
		push(MODE_START, 62'd100, 6'd0);
		push(MODE_FIRE, gen_t + 62'd100_000, 6'd49);
		push(MODE_FIRE, gen_t + 62'd1, 6'd49);
		drain();

		// random part over several settings, extremes included
		run_phase(40'hFF_FFFF_FFFF, 11'd1024, 98);
		run_phase(40'd10_001, 11'd1, 98);
		run_phase(40'd1_000_000, 11'd3, 98);
		run_phase(40'd10_000, 11'd7, 30);
		run_phase(40'd0, 11'd2047, 30);
		run_phase(40'd50_000, 11'd0, 98);
		run_phase(40'd123_456_789, 11'd2047, 98);
		run_phase({$urandom, 8'($urandom)}, CPU_W'($urandom_range(0, 2047)), 98);
		run_phase({$urandom, 8'($urandom)}, CPU_W'($urandom_range(0, 2047)), 98);
		run_phase(40'd1_000_000, 11'd1, 98);

		// tail: longer than the slowest item latency
		repeat (200) @(posedge clk);
		if (n_fail == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// hard limit, several times the slowest legal run
	initial begin
		#8_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
